// ===== rtl/sbi_pkg.sv =====
// Shared constants and types for the segment/box slab test pipeline.
// No dependencies.
package sbi_pkg;

    localparam int CoordWidthDef = 32;
    localparam int FieldWidth    = 32;
    localparam int NumAxes       = 3;
    localparam int NumFields     = 12;
    localparam int ThrWidth      = 17;
    localparam int InDataWidth   = FieldWidth * NumFields;
    localparam int OutDataWidth  = 8;
    localparam logic [ThrWidth-1:0] ThrReset = 17'd1;

    // per-axis flags handed from the prep stages to the product stage
    typedef struct packed {
        logic [NumAxes-1:0] axis_par;  // axis counts as parallel
        logic [NumAxes-1:0] axis_ok;   // single-axis checks passed
    } t_axis_flags;

endpackage

// ===== rtl/segment_box_intersect_core.sv =====
// Channel   Dir  Fields (low bit up)
// s_axis    in   tdata: start_x/y/z, end_x/y/z, box_min_x/y/z, box_max_x/y/z (32b each)
// m_axis    out  tdata: hit (bit 0), zero fill to 8 bits
// cfg       in   parallel_threshold (17b), always ready
//
// One beat per cycle while m_axis is not stalled: stage 1 differences, stage 2 order
// and axis checks, stage 3 cross products, stage 4 compares and output reg.
// Each stage holds its own valid and moves when the next one is free.
// Synchronous active-low reset clears valids and sets threshold to 1.
// Depends on sbi_pkg, sbi_prep, sbi_mul, sbi_cmp.
module segment_box_intersect_core
    import sbi_pkg::*;
#(
    parameter int COORD_WIDTH = CoordWidthDef
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [InDataWidth-1:0]  i_s_tdata,   // start xyz, end xyz, min xyz, max xyz
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [OutDataWidth-1:0] o_m_tdata,   // hit
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [ThrWidth-1:0]     i_cfg_data
);
    logic [ThrWidth-1:0] r_thr;
    logic v_a, rdy_a, v_b, rdy_b, hit;
    logic [NumAxes-1:0][COORD_WIDTH:0] dd, n0, n1;
    logic [NumAxes-1:0][NumAxes-1:0][2*COORD_WIDTH+2:0] p, q;
    t_axis_flags fl_a, fl_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ThrReset;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    sbi_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
        .i_clk, .i_rst_n,
        .i_valid(i_s_tvalid), .o_ready(o_s_tready), .i_data(i_s_tdata), .i_thr(r_thr),
        .o_valid(v_a), .i_ready(rdy_a), .o_dd(dd), .o_n0(n0), .o_n1(n1), .o_flags(fl_a)
    );

    sbi_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
        .i_clk, .i_rst_n,
        .i_valid(v_a), .o_ready(rdy_a), .i_dd(dd), .i_n0(n0), .i_n1(n1), .i_flags(fl_a),
        .o_valid(v_b), .i_ready(rdy_b), .o_p(p), .o_q(q), .o_flags(fl_b)
    );

    sbi_cmp #(.COORD_WIDTH(COORD_WIDTH)) u_cmp (
        .i_clk, .i_rst_n,
        .i_valid(v_b), .o_ready(rdy_b), .i_p(p), .i_q(q), .i_flags(fl_b),
        .o_valid(o_m_tvalid), .i_ready(i_m_tready), .o_hit(hit)
    );

    assign o_m_tdata = {{(OutDataWidth-1){1'b0}}, hit};

endmodule

// ===== rtl/sbi_prep.sv =====
// Stages 1 and 2: differences, parallel test, slab numerators in order.
// Depends on sbi_pkg.
module sbi_prep
    import sbi_pkg::*;
#(
    parameter int COORD_WIDTH = CoordWidthDef
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [InDataWidth-1:0]            i_data,
    input  logic [ThrWidth-1:0]               i_thr,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [NumAxes-1:0][COORD_WIDTH:0] o_dd,
    output logic [NumAxes-1:0][COORD_WIDTH:0] o_n0,
    output logic [NumAxes-1:0][COORD_WIDTH:0] o_n1,
    output t_axis_flags                       o_flags
);
    localparam int W  = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 1;

    logic en1, en2;
    logic r_v1, r_v2;
    logic signed [NumAxes-1:0][DW-1:0] r_d, r_n0r, r_n1r;
    logic [NumAxes-1:0] r_out;
    logic signed [NumAxes-1:0][DW-1:0] n_d, n_n0r, n_n1r;
    logic [NumAxes-1:0] n_out;
    logic [NumAxes-1:0][DW-1:0] r_dd, n_dd;
    logic signed [NumAxes-1:0][DW-1:0] r_n0, r_n1, n_n0, n_n1;
    t_axis_flags r_flags, n_flags;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    function automatic logic signed [DW-1:0] coord(input logic [FieldWidth-1:0] f);
        logic [FieldWidth+W-1:0] e;
        e = {{W{1'b0}}, f};
        return signed'({e[W-1], e[W-1:0]});
    endfunction

    always_comb begin
        logic signed [DW-1:0] o, e, lo, hi;
        for (int i = 0; i < NumAxes; i++) begin
            o  = coord(i_data[FieldWidth*i +: FieldWidth]);
            e  = coord(i_data[FieldWidth*(3+i) +: FieldWidth]);
            lo = coord(i_data[FieldWidth*(6+i) +: FieldWidth]);
            hi = coord(i_data[FieldWidth*(9+i) +: FieldWidth]);
            n_d[i]   = e - o;
            n_n0r[i] = lo - o;
            n_n1r[i] = hi - o;
            n_out[i] = (o < lo) || (o > hi);
        end
    end

    always_comb begin
        logic signed [DW-1:0] a, b;
        logic par;
        for (int i = 0; i < NumAxes; i++) begin
            n_dd[i] = r_d[i][DW-1] ? DW'(-r_d[i]) : DW'(r_d[i]);
            a = r_d[i][DW-1] ? -r_n0r[i] : r_n0r[i];
            b = r_d[i][DW-1] ? -r_n1r[i] : r_n1r[i];
            n_n0[i] = (a > b) ? b : a;
            n_n1[i] = (a > b) ? a : b;
            par = (n_dd[i] == '0) || (n_dd[i] < DW'(i_thr));
            n_flags.axis_par[i] = par;
            n_flags.axis_ok[i]  = par ? !r_out[i]
                                      : (!n_n1[i][DW-1] &&
                                         (signed'(n_n0[i]) <= signed'({1'b0, n_dd[i]})));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
        if (en1 && i_valid) begin
            r_d   <= n_d;
            r_n0r <= n_n0r;
            r_n1r <= n_n1r;
            r_out <= n_out;
        end
        if (en2 && r_v1) begin
            r_dd    <= n_dd;
            r_n0    <= n_n0;
            r_n1    <= n_n1;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_v2;
    assign o_dd    = r_dd;
    assign o_n0    = r_n0;
    assign o_n1    = r_n1;
    assign o_flags = r_flags;

    for (genvar g = 0; g < NumAxes; g++) begin : g_chk
        a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_v2 |-> signed'(r_n0[g]) <= signed'(r_n1[g]))
            else $error("slab numerators out of order");
        a_zero_par: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_v2 && r_dd[g] == '0) |-> r_flags.axis_par[g])
            else $error("zero direction not treated as parallel");
    end

endmodule

// ===== rtl/sbi_mul.sv =====
// Stage 3: cross products of entry and exit numerators with directions.
// Depends on sbi_pkg.
module sbi_mul
    import sbi_pkg::*;
#(
    parameter int COORD_WIDTH = CoordWidthDef
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_valid,
    output logic                                               o_ready,
    input  logic [NumAxes-1:0][COORD_WIDTH:0]                  i_dd,
    input  logic [NumAxes-1:0][COORD_WIDTH:0]                  i_n0,
    input  logic [NumAxes-1:0][COORD_WIDTH:0]                  i_n1,
    input  t_axis_flags                                        i_flags,
    output logic                                               o_valid,
    input  logic                                               i_ready,
    output logic [NumAxes-1:0][NumAxes-1:0][2*COORD_WIDTH+2:0] o_p,
    output logic [NumAxes-1:0][NumAxes-1:0][2*COORD_WIDTH+2:0] o_q,
    output t_axis_flags                                        o_flags
);
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW + 1;

    logic en, r_v;
    logic signed [NumAxes-1:0][NumAxes-1:0][PW-1:0] r_p, r_q, n_p, n_q;
    t_axis_flags r_flags;

    assign en      = !r_v || i_ready;
    assign o_ready = en;

    // entry of axis i times dir of axis j against exit of axis j times dir of axis i
    always_comb begin
        for (int i = 0; i < NumAxes; i++) begin
            for (int j = 0; j < NumAxes; j++) begin
                n_p[i][j] = PW'(signed'(i_n0[i]) * signed'({1'b0, i_dd[j]}));
                n_q[i][j] = PW'(signed'(i_n1[j]) * signed'({1'b0, i_dd[i]}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
        if (en && i_valid) begin
            r_p     <= n_p;
            r_q     <= n_q;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_v;
    assign o_p     = r_p;
    assign o_q     = r_q;
    assign o_flags = r_flags;

endmodule

// ===== rtl/sbi_cmp.sv =====
// Stage 4: compare cross products, fold all checks into the hit flag.
// Depends on sbi_pkg.
module sbi_cmp
    import sbi_pkg::*;
#(
    parameter int COORD_WIDTH = CoordWidthDef
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_valid,
    output logic                                               o_ready,
    input  logic [NumAxes-1:0][NumAxes-1:0][2*COORD_WIDTH+2:0] i_p,
    input  logic [NumAxes-1:0][NumAxes-1:0][2*COORD_WIDTH+2:0] i_q,
    input  t_axis_flags                                        i_flags,
    output logic                                               o_valid,
    input  logic                                               i_ready,
    output logic                                               o_hit
);
    logic en, r_v, r_hit, n_hit;

    assign en      = !r_v || i_ready;
    assign o_ready = en;

    always_comb begin
        n_hit = &i_flags.axis_ok;
        for (int i = 0; i < NumAxes; i++) begin
            for (int j = 0; j < NumAxes; j++) begin
                if (i != j && !i_flags.axis_par[i] && !i_flags.axis_par[j] &&
                    (signed'(i_p[i][j]) > signed'(i_q[i][j]))) begin
                    n_hit = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
        if (en && i_valid) r_hit <= n_hit;
    end

    assign o_valid = r_v;
    assign o_hit   = r_hit;

    a_fail_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && i_valid && !(&i_flags.axis_ok)) |=> !r_hit)
        else $error("hit reported although an axis check failed");

endmodule

// ===== dv/segment_box_intersect_core_test.sv =====
// Self-checking bench for segment_box_intersect_core: random and directed segment/box
// beats are checked against an exact rational slab-test predictor across several thresholds.
// Depends on sbi_pkg and the core RTL.
module segment_box_intersect_core_test;
    import sbi_pkg::*;

    localparam int ONE = 32'h0001_0000;

    typedef logic [NumFields-1:0][FieldWidth-1:0] seg_box_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [InDataWidth-1:0]  i_s_tdata = '0;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [OutDataWidth-1:0] o_m_tdata;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [ThrWidth-1:0]     i_cfg_data = '0;

    seg_box_t            pending_beats[$];
    logic                hit_expected[$];
    seg_box_t            cur_beat;
    logic [ThrWidth-1:0] thr_model = ThrReset;
    logic [ThrWidth-1:0] thr_request;
    bit                  thr_pending = 0;
    int                  thr_writes = 0;
    bit                  gaps_on = 1;
    bit                  long_hold_req = 0;
    int                  send_gap = 0;
    int                  sink_hold = 0;
    int                  fail_count = 0;

    segment_box_intersect_core dut (.*);

    always #4 i_clk = ~i_clk;

    // sign of an/ad - cn/cd with positive denominators, exact
    function automatic int frac_cmp(longint an, longint ad, longint cn, longint cd);
        logic signed [127:0] a, b, c, d;
        a = an; b = ad; c = cn; d = cd;
        if (a * d > c * b) return 1;
        if (a * d < c * b) return -1;
        return 0;
    endfunction

    function automatic logic slab_hit(seg_box_t b, logic [ThrWidth-1:0] thr);
        longint o, e, lo, hi, d, dd, n0, n1, sw;
        longint tn, td, un, ud;
        tn = 0; td = 1; un = 1; ud = 1;
        for (int i = 0; i < NumAxes; i++) begin
            o  = $signed(b[i]);
            e  = $signed(b[3+i]);
            lo = $signed(b[6+i]);
            hi = $signed(b[9+i]);
            d  = e - o;
            dd = (d < 0) ? -d : d;
            if (d == 0 || dd < longint'(thr)) begin
                if (o < lo || o > hi) return 1'b0;
            end else begin
                n0 = lo - o;
                n1 = hi - o;
                if (d < 0) begin
                    n0 = -n0;
                    n1 = -n1;
                end
                if (n0 > n1) begin
                    sw = n0; n0 = n1; n1 = sw;
                end
                if (frac_cmp(n0, dd, tn, td) > 0) begin
                    tn = n0; td = dd;
                end
                if (frac_cmp(n1, dd, un, ud) < 0) begin
                    un = n1; ud = dd;
                end
                if (frac_cmp(tn, td, un, ud) > 0) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic seg_box_t mk(int sx, int sy, int sz, int ex, int ey, int ez,
                                    int lx, int ly, int lz, int hx, int hy, int hz);
        seg_box_t b;
        b[0] = sx; b[1] = sy; b[2] = sz; b[3] = ex; b[4] = ey; b[5] = ez;
        b[6] = lx; b[7] = ly; b[8] = lz; b[9] = hx; b[10] = hy; b[11] = hz;
        return b;
    endfunction

    function automatic seg_box_t rand_seg_box();
        seg_box_t b;
        int kind, c, half, sw;
        logic [31:0] corners[4];
        kind = $urandom_range(0, 9);
        corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
        for (int i = 0; i < NumAxes; i++) begin
            if (kind < 2) begin
                b[i] = $urandom; b[3+i] = $urandom; b[6+i] = $urandom; b[9+i] = $urandom;
            end else if (kind == 2) begin
                b[i] = corners[$urandom_range(0, 3)];
                b[3+i] = corners[$urandom_range(0, 3)];
                b[6+i] = corners[$urandom_range(0, 3)];
                b[9+i] = corners[$urandom_range(0, 3)];
            end else begin
                c    = int'($urandom & 32'h00ff_ffff) - 32'h0080_0000;
                half = $urandom_range(0, 1 << 18);
                b[6+i] = c - half;
                b[9+i] = c + half;
                if ($urandom_range(0, 15) == 0) begin
                    sw = b[6+i]; b[6+i] = b[9+i]; b[9+i] = sw;
                end
                b[i] = c + int'($urandom_range(0, 1 << 20)) - (1 << 19);
                case ($urandom_range(0, 5))
                    0: b[3+i] = b[i];
                    1: b[3+i] = b[i] + int'($urandom_range(0, 280000)) - 140000;
                    default: b[3+i] = c + int'($urandom_range(0, 1 << 20)) - (1 << 19);
                endcase
            end
        end
        return b;
    endfunction

    // sender: present queued beats, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                hit_expected.push_back(slab_hit(cur_beat, thr_model));
            if (i_s_tvalid && !o_s_tready) begin
                // hold the beat
            end else if (send_gap > 0) begin
                send_gap--;
                i_s_tvalid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                cur_beat = pending_beats.pop_front();
                i_s_tdata  <= cur_beat;
                i_s_tvalid <= 1'b1;
                if (gaps_on && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 13);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold--;
            i_m_tready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 0;
            sink_hold = 400;
            i_m_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            sink_hold = $urandom_range(0, 12);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (hit_expected.size() == 0) begin
                $error("unexpected result beat, hit=%0b", o_m_tdata[0]);
                fail_count++;
            end else begin
                want = hit_expected.pop_front();
                if (o_m_tdata[0] !== want) begin
                    $error("hit mismatch: expected %0b actual %0b", want, o_m_tdata[0]);
                    fail_count++;
                end
            end
        end
    end

    // threshold register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            thr_model = i_cfg_data;
            thr_writes++;
            i_cfg_valid <= 1'b0;
        end else if (thr_pending && !i_cfg_valid) begin
            thr_pending = 0;
            i_cfg_data  <= thr_request;
            i_cfg_valid <= 1'b1;
        end
    end

    task automatic drain();
        do @(posedge i_clk);
        while (pending_beats.size() > 0 || i_s_tvalid || send_gap > 0 ||
               hit_expected.size() > 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [ThrWidth-1:0] v);
        int n;
        n = thr_writes;
        thr_request = v;
        thr_pending = 1;
        while (thr_writes == n) @(posedge i_clk);
    endtask

    task automatic add_directed();
        pending_beats.push_back(mk(-2*ONE, ONE/2, ONE/2, 2*ONE, ONE/2, ONE/2,
                                   0, 0, 0, ONE, ONE, ONE));
        pending_beats.push_back(mk(-2*ONE, 3*ONE, ONE/2, 2*ONE, 3*ONE, ONE/2,
                                   0, 0, 0, ONE, ONE, ONE));
        pending_beats.push_back(mk(ONE/2, ONE/2, ONE/2, ONE/2, ONE/2, ONE/2,
                                   0, 0, 0, ONE, ONE, ONE));
        pending_beats.push_back(mk(2*ONE, ONE/2, ONE/2, 2*ONE, ONE/2, ONE/2,
                                   0, 0, 0, ONE, ONE, ONE));
        // inverted box on a parallel axis, then on a sloped one
        pending_beats.push_back(mk(ONE/2, ONE/2, ONE/2, ONE/2, 2*ONE, 2*ONE,
                                   ONE, 0, 0, 0, ONE, ONE));
        pending_beats.push_back(mk(-ONE, -ONE, -ONE, 2*ONE, 2*ONE, 2*ONE,
                                   ONE, ONE, ONE, 0, 0, 0));
        // endpoint exactly on a corner
        pending_beats.push_back(mk(-ONE, -ONE, -ONE, 0, 0, 0, 0, 0, 0, ONE, ONE, ONE));
        pending_beats.push_back(mk(-ONE, -ONE, -ONE, -1, -1, -1, 0, 0, 0, ONE, ONE, ONE));
        pending_beats.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        pending_beats.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                   0, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_beats.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        pending_beats.push_back(mk(0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1));
        pending_beats.push_back(mk(0, 0, 0, 1, 0, 0, 2, 0, 0, 3, 0, 0));
        pending_beats.push_back(mk(0, ONE/2, ONE/2, ONE, ONE/2, ONE/2,
                                   32'h8000_0000, 0, 0, 32'h7fff_ffff, ONE, ONE));
    endtask

    task automatic add_random(int n);
        for (int k = 0; k < n; k++) pending_beats.push_back(rand_seg_box());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_directed();
        add_random(60);
        drain();

        set_threshold('0);
        add_directed();
        long_hold_req = 1;
        add_random(70);
        drain();

        set_threshold(17'h1ffff);
        add_directed();
        add_random(70);
        drain();

        set_threshold(17'd65536);
        add_random(70);
        drain();

        set_threshold(ThrWidth'($urandom_range(2, 65535)));
        add_random(70);
        drain();

        set_threshold(17'd1);
        gaps_on = 0;
        add_random(70);
        drain();

        if (fail_count == 0 && hit_expected.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
